FILE: rtl/assert_macros.svh
// Concurrent check helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");

`endif

FILE: rtl/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int LINK_BYTES_DEF   = 4;
  localparam int ADDRESS_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_RESIZE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_NULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_BAD_ALIGN = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_FIRST_HEADER = 2'd0,
    CFG_REGION_LEN   = 2'd1,
    CFG_KERNEL_LEN   = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_ALLOC_RD, S_ALLOC_ALN, S_ALLOC_TOT, S_ALLOC_CMP,
    S_SCAN, S_SPLIT_A, S_SPLIT_B, S_FIND, S_RSZ_RD, S_RSZ_CMP,
    S_REL_RD, S_REL_NRD, S_REL_NMRG, S_REL_PCHK, S_REL_PMRG, S_DONE
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] request_size;
    logic [12:0] alignment;
    logic [31:0] user_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_address;
    status_t     status;
    logic        moved;
  } out_item_t;

  // Lowest set bit of the header address halved, capped at 64, never 0.
  function automatic logic [12:0] default_align(input logic [31:0] fha);
    logic [12:0] a;
    a = 13'd64;
    for (int k = 6; k >= 0; k--) begin
      if (fha[k]) a = (k == 0) ? 13'd1 : 13'(1 << (k - 1));
    end
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ffha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------
// command   | start & !busy             | cmd (in_item_t)
// result    | done, one-cycle strobe    | result (out_item_t)
// config    | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// Block table lives in five registered-read RAMs; free and in-use marks
// are flip-flops. Allocate walks the list block by block (read, align, then
// total and compare for a free block), scanning for a spare entry to split.
// Free and resize sweep the table for the user address, one entry a cycle,
// then merge the released block with free neighbours. Reset is synchronous and
// needs no clearing pass. Results cannot be stalled; cfg_ready is always high.
`include "assert_macros.svh"
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int LINK_BYTES   = ffha_pkg::LINK_BYTES_DEF,
  parameter int ADDRESS_BITS = ffha_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire ffha_pkg::in_item_t  cmd,
  output logic                     done,
  output ffha_pkg::out_item_t      result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int IW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = AW + 1;
  localparam int AB = ADDRESS_BITS;
  localparam int W  = (AB > 32) ? AB : 32;
  localparam logic [IW-1:0] NONE = IW'(MAX_BLOCKS);
  localparam logic [AB-1:0] HL_A = AB'(HEADER_BYTES + LINK_BYTES);
  localparam logic [AB-1:0] H_A  = AB'(HEADER_BYTES);
  localparam logic [AB-1:0] L_A  = AB'(LINK_BYTES);
  localparam logic [W-1:0]  H_W  = W'(HEADER_BYTES);
  localparam logic [31:0]   H_S  = 32'(HEADER_BYTES);
  localparam logic [31:0]   HL_S = 32'(HEADER_BYTES + LINK_BYTES);

  ffha_pkg::state_t state, state_next;

  logic [31:0] cfg_fha, cfg_rlen, cfg_klen;
  logic [MAX_BLOCKS-1:0] used_bits, free_bits;
  logic [IW-1:0] head;

  // transaction payload and work registers
  ffha_pkg::op_t op_r;
  logic [31:0]   size_r, uaddr_r, res;
  ffha_pkg::status_t stat;
  logic          mvd, mv, cand, did_split, pend;
  logic [12:0]   al;
  logic [IW-1:0] cur, nx, ni, pi;
  logic [CW-1:0] steps, fcnt;
  logic [AW-1:0] sidx, sp, ri, pidx;
  logic [AB-1:0] base, us, total, new_hdr, set_user;
  logic [31:0]   bytes_r, new_bytes, cur_bytes, bi;

  // RAM ports
  logic [AW-1:0] rd_addr;
  logic [AB-1:0] rd_hdr, rd_user;
  logic [31:0]   rd_bytes;
  logic [IW-1:0] rd_next, rd_prev;
  logic          hdr_we, bytes_we, user_we, next_we, prev_we;
  logic [AW-1:0] hdr_wa, bytes_wa, user_wa, next_wa, prev_wa;
  logic [AB-1:0] hdr_wd, user_wd;
  logic [31:0]   bytes_wd;
  logic [IW-1:0] next_wd, prev_wd;

  ffha_ram #(.WIDTH(AB), .DEPTH(MAX_BLOCKS)) u_hdr (
    .clk, .we(hdr_we), .waddr(hdr_wa), .wdata(hdr_wd), .raddr(rd_addr), .rdata(rd_hdr));
  ffha_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_bytes (
    .clk, .we(bytes_we), .waddr(bytes_wa), .wdata(bytes_wd), .raddr(rd_addr),
    .rdata(rd_bytes));
  ffha_ram #(.WIDTH(AB), .DEPTH(MAX_BLOCKS)) u_user (
    .clk, .we(user_we), .waddr(user_wa), .wdata(user_wd), .raddr(rd_addr),
    .rdata(rd_user));
  ffha_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_next (
    .clk, .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(rd_addr),
    .rdata(rd_next));
  ffha_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_prev (
    .clk, .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(rd_addr),
    .rdata(rd_prev));

  // helpers
  logic [AW-1:0] ci;
  logic          cur_ok, steps_end, fcnt_end, bad_align, hit, fit, split_c;
  logic          rsz_fits, ex_big, n_mrg, p_mrg, nx_ok, ni_ok, rdn_ok;
  logic [12:0]   da, al_in;
  logic [AB-1:0] alm1, us_calc, total_calc, size_ab;
  logic [31:0]   excess;

  always_comb begin
    ci         = cur[AW-1:0];
    cur_ok     = cur < NONE;
    steps_end  = steps == CW'(MAX_BLOCKS);
    fcnt_end   = fcnt == CW'(MAX_BLOCKS);
    da         = ffha_pkg::default_align(cfg_fha);
    al_in      = (cmd.alignment == 13'd0) ? da : cmd.alignment;
    bad_align  = (al_in & (al_in - 13'd1)) != 13'd0;
    alm1       = AB'(al) - AB'(1);
    us_calc    = (rd_hdr + HL_A + alm1) & ~alm1;
    size_ab    = AB'(W'(size_r));
    total_calc = us + size_ab - base;
    fit        = W'(bytes_r) >= W'(total);
    split_c    = W'(bytes_r) > W'(AB'(total + H_A));
    hit        = pend && used_bits[pidx] && !free_bits[pidx] &&
                 (W'(rd_user) == W'(uaddr_r));
    rsz_fits   = rd_bytes >= size_r;
    excess     = rd_bytes - size_r;
    ex_big     = excess >= HL_S;
    rdn_ok     = rd_next < NONE;
    n_mrg      = rdn_ok && used_bits[rd_next[AW-1:0]] && free_bits[rd_next[AW-1:0]];
    p_mrg      = (pi < NONE) && used_bits[pi[AW-1:0]] && free_bits[pi[AW-1:0]];
    nx_ok      = nx < NONE;
    ni_ok      = ni < NONE;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::S_IDLE: begin
        if (start) begin
          unique case (cmd.operation)
            ffha_pkg::OP_INIT:
              state_next = (cfg_rlen == 32'd0) ? ffha_pkg::S_DONE : ffha_pkg::S_INIT;
            ffha_pkg::OP_ALLOC:
              state_next = bad_align ? ffha_pkg::S_DONE : ffha_pkg::S_ALLOC_RD;
            ffha_pkg::OP_FREE:
              state_next = (cmd.user_address == 32'd0) ? ffha_pkg::S_DONE : ffha_pkg::S_FIND;
            ffha_pkg::OP_RESIZE:
              state_next = (cmd.user_address == 32'd0) ? ffha_pkg::S_ALLOC_RD :
                           ffha_pkg::S_FIND;
            default: state_next = ffha_pkg::S_IDLE;
          endcase
        end
      end
      ffha_pkg::S_INIT:      state_next = ffha_pkg::S_DONE;
      ffha_pkg::S_ALLOC_RD:
        state_next = (!cur_ok || steps_end) ? ffha_pkg::S_DONE : ffha_pkg::S_ALLOC_ALN;
      ffha_pkg::S_ALLOC_ALN: state_next = cand ? ffha_pkg::S_ALLOC_TOT : ffha_pkg::S_ALLOC_RD;
      ffha_pkg::S_ALLOC_TOT: state_next = ffha_pkg::S_ALLOC_CMP;
      ffha_pkg::S_ALLOC_CMP: begin
        if (!fit)        state_next = ffha_pkg::S_ALLOC_RD;
        else if (split_c) state_next = ffha_pkg::S_SCAN;
        else             state_next = ffha_pkg::S_SPLIT_B;
      end
      ffha_pkg::S_SCAN: begin
        if (!used_bits[sidx])                   state_next = ffha_pkg::S_SPLIT_A;
        else if (sidx == AW'(MAX_BLOCKS - 1))   state_next = ffha_pkg::S_SPLIT_B;
      end
      ffha_pkg::S_SPLIT_A:   state_next = ffha_pkg::S_SPLIT_B;
      ffha_pkg::S_SPLIT_B:   state_next = mv ? ffha_pkg::S_REL_RD : ffha_pkg::S_DONE;
      ffha_pkg::S_FIND: begin
        if (hit) begin
          state_next = (op_r == ffha_pkg::OP_FREE || size_r == 32'd0) ?
                       ffha_pkg::S_REL_RD : ffha_pkg::S_RSZ_RD;
        end else if (fcnt_end) begin
          state_next = ffha_pkg::S_DONE;
        end
      end
      ffha_pkg::S_RSZ_RD:    state_next = ffha_pkg::S_RSZ_CMP;
      ffha_pkg::S_RSZ_CMP: begin
        if (!rsz_fits)   state_next = ffha_pkg::S_ALLOC_RD;
        else if (ex_big) state_next = ffha_pkg::S_SCAN;
        else             state_next = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_REL_RD:    state_next = ffha_pkg::S_REL_NRD;
      ffha_pkg::S_REL_NRD:   state_next = n_mrg ? ffha_pkg::S_REL_NMRG : ffha_pkg::S_REL_PCHK;
      ffha_pkg::S_REL_NMRG:  state_next = ffha_pkg::S_REL_PCHK;
      ffha_pkg::S_REL_PCHK:  state_next = p_mrg ? ffha_pkg::S_REL_PMRG : ffha_pkg::S_DONE;
      ffha_pkg::S_REL_PMRG:  state_next = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE:      state_next = ffha_pkg::S_IDLE;
      default:               state_next = ffha_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_addr  = ci;
    hdr_we   = 1'b0; hdr_wa   = sp; hdr_wd   = new_hdr;
    bytes_we = 1'b0; bytes_wa = sp; bytes_wd = new_bytes;
    user_we  = 1'b0; user_wa  = sp; user_wd  = '0;
    next_we  = 1'b0; next_wa  = sp; next_wd  = nx;
    prev_we  = 1'b0; prev_wa  = sp; prev_wd  = cur;
    unique case (state)
      ffha_pkg::S_INIT: begin
        hdr_we   = 1'b1; hdr_wa   = '0; hdr_wd   = AB'(W'(cfg_fha));
        bytes_we = 1'b1; bytes_wa = '0; bytes_wd = cfg_rlen - cfg_klen - H_S;
        user_we  = 1'b1; user_wa  = '0;
        next_we  = 1'b1; next_wa  = '0; next_wd  = NONE;
        prev_we  = 1'b1; prev_wa  = '0; prev_wd  = NONE;
      end
      ffha_pkg::S_FIND:     rd_addr = fcnt[AW-1:0];
      ffha_pkg::S_RSZ_RD,
      ffha_pkg::S_REL_RD:   rd_addr = ri;
      ffha_pkg::S_REL_NRD:  rd_addr = rd_next[AW-1:0];
      ffha_pkg::S_REL_PCHK: rd_addr = pi[AW-1:0];
      ffha_pkg::S_SPLIT_A: begin
        hdr_we = 1'b1; bytes_we = 1'b1; user_we = 1'b1; next_we = 1'b1; prev_we = 1'b1;
      end
      ffha_pkg::S_SPLIT_B: begin
        user_we = 1'b1; user_wa = ci; user_wd = set_user;
        if (did_split) begin
          bytes_we = 1'b1; bytes_wa = ci; bytes_wd = cur_bytes;
          next_we  = 1'b1; next_wa  = ci; next_wd  = IW'(sp);
          prev_we  = nx_ok; prev_wa = nx[AW-1:0]; prev_wd = IW'(sp);
        end
      end
      ffha_pkg::S_REL_NMRG: begin
        bytes_we = 1'b1; bytes_wa = ri; bytes_wd = bi + H_S + rd_bytes;
        next_we  = 1'b1; next_wa  = ri; next_wd  = rd_next;
        prev_we  = rdn_ok; prev_wa = rd_next[AW-1:0]; prev_wd = IW'(ri);
      end
      ffha_pkg::S_REL_PMRG: begin
        bytes_we = 1'b1; bytes_wa = pi[AW-1:0]; bytes_wd = rd_bytes + H_S + bi;
        next_we  = 1'b1; next_wa  = pi[AW-1:0]; next_wd  = ni;
        prev_we  = ni_ok; prev_wa = ni[AW-1:0]; prev_wd = pi;
      end
      default: ;
    endcase
  end

  assign busy      = state != ffha_pkg::S_IDLE;
  assign cfg_ready = 1'b1;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffha_pkg::S_IDLE;
      done      <= 1'b0;
      used_bits <= '0;
      free_bits <= '0;
      head      <= NONE;
      cfg_fha   <= '0;
      cfg_rlen  <= '0;
      cfg_klen  <= '0;
    end else begin
      state <= state_next;
      done  <= state == ffha_pkg::S_DONE;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ffha_pkg::CFG_FIRST_HEADER: cfg_fha  <= cfg_data;
          ffha_pkg::CFG_REGION_LEN:   cfg_rlen <= cfg_data;
          ffha_pkg::CFG_KERNEL_LEN:   cfg_klen <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ffha_pkg::S_INIT: begin
          used_bits    <= '0;
          free_bits    <= '0;
          used_bits[0] <= 1'b1;
          free_bits[0] <= 1'b1;
          head         <= '0;
        end
        ffha_pkg::S_SPLIT_A: begin
          used_bits[sp] <= 1'b1;
          free_bits[sp] <= 1'b1;
        end
        ffha_pkg::S_SPLIT_B:  free_bits[ci] <= 1'b0;
        ffha_pkg::S_REL_RD:   free_bits[ri] <= 1'b1;
        ffha_pkg::S_REL_NMRG: used_bits[ni[AW-1:0]] <= 1'b0;
        ffha_pkg::S_REL_PMRG: used_bits[ri] <= 1'b0;
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    case (state)
      ffha_pkg::S_IDLE: begin
        op_r    <= cmd.operation;
        size_r  <= cmd.request_size;
        uaddr_r <= cmd.user_address;
        res     <= '0;
        mvd     <= 1'b0;
        mv      <= 1'b0;
        cur     <= head;
        steps   <= '0;
        fcnt    <= '0;
        pend    <= 1'b0;
        al      <= (cmd.operation == ffha_pkg::OP_RESIZE) ? da : al_in;
        stat    <= ffha_pkg::ST_OK;
        if (cmd.operation == ffha_pkg::OP_INIT && cfg_rlen == 32'd0)
          stat <= ffha_pkg::ST_EMPTY;
        if (cmd.operation == ffha_pkg::OP_ALLOC && bad_align)
          stat <= ffha_pkg::ST_BAD_ALIGN;
        if (cmd.operation == ffha_pkg::OP_FREE && cmd.user_address == 32'd0)
          stat <= ffha_pkg::ST_NULL;
      end
      ffha_pkg::S_ALLOC_RD: begin
        if (!cur_ok || steps_end) stat <= ffha_pkg::ST_NO_FIT;
        else cand <= used_bits[ci] && free_bits[ci];
      end
      ffha_pkg::S_ALLOC_ALN: begin
        base    <= rd_hdr;
        bytes_r <= rd_bytes;
        nx      <= rd_next;
        us      <= us_calc;
        if (!cand) begin
          cur   <= rd_next;
          steps <= steps + CW'(1);
        end
      end
      ffha_pkg::S_ALLOC_TOT: total <= total_calc;
      ffha_pkg::S_ALLOC_CMP: begin
        if (fit) begin
          res       <= 32'(W'(us));
          set_user  <= us;
          new_hdr   <= base + total;
          new_bytes <= 32'(W'(bytes_r) - W'(total) - H_W);
          cur_bytes <= 32'(W'(total) - H_W);
          sidx      <= '0;
          did_split <= 1'b0;
        end else begin
          cur   <= nx;
          steps <= steps + CW'(1);
        end
      end
      ffha_pkg::S_SCAN: begin
        if (!used_bits[sidx]) begin
          sp        <= sidx;
          did_split <= 1'b1;
        end else begin
          sidx <= sidx + AW'(1);
        end
      end
      ffha_pkg::S_SPLIT_B: if (mv) mvd <= 1'b1;
      ffha_pkg::S_FIND: begin
        if (hit) begin
          ri   <= pidx;
          pend <= 1'b0;
        end else if (fcnt_end) begin
          stat <= ffha_pkg::ST_UNKNOWN;
        end else begin
          pend <= 1'b1;
          pidx <= fcnt[AW-1:0];
          fcnt <= fcnt + CW'(1);
        end
      end
      ffha_pkg::S_RSZ_CMP: begin
        if (rsz_fits) begin
          res       <= 32'(W'(rd_user));
          cur       <= IW'(ri);
          nx        <= rd_next;
          new_hdr   <= rd_hdr + H_A + size_ab + L_A;
          new_bytes <= excess - HL_S;
          cur_bytes <= size_r;
          set_user  <= rd_user;
          sidx      <= '0;
          did_split <= 1'b0;
        end else begin
          mv    <= 1'b1;
          cur   <= head;
          steps <= '0;
        end
      end
      ffha_pkg::S_REL_NRD: begin
        bi <= rd_bytes;
        ni <= rd_next;
        pi <= rd_prev;
      end
      ffha_pkg::S_REL_NMRG: begin
        bi <= bi + H_S + rd_bytes;
        ni <= rd_next;
      end
      ffha_pkg::S_DONE: begin
        result.result_address <= res;
        result.status         <= stat;
        result.moved          <= mvd;
      end
      default: ;
    endcase
  end

  `CHK_IMPL(a_done_idle, clk, rst, done, !busy)
  `CHK_IMPL(a_moved_ok, clk, rst, done && result.moved, result.status == ffha_pkg::ST_OK)
  `CHK_IMPL(a_fail_zero, clk, rst, done && result.status != ffha_pkg::ST_OK, result.result_address == 32'd0)
  `CHK_IMPL(a_head_used, clk, rst, head != NONE, used_bits[head[AW-1:0]])

endmodule
`default_nettype wire
